// ===== src/display_test_pattern_generator_macros.svh =====
// Assertion macros used by the display test pattern generator checker.
`ifndef DISPLAY_TEST_PATTERN_GENERATOR_MACROS_SVH
`define DISPLAY_TEST_PATTERN_GENERATOR_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define DTPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DTPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dtpg_pkg.sv =====
// Package: types, constants and register codes of the display test pattern generator.
`timescale 1ns / 1ps
package dtpg_pkg;

  localparam int COORD_LIMIT = 4096;
  localparam int COORD_W     = $clog2(COORD_LIMIT);
  localparam int DIM_W       = 12;
  localparam int STRIDE_W    = 13;
  localparam int MODE_W      = 4;
  localparam int COLOR_W     = 16;
  localparam int ADDR_W      = 24;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_W   = 3;

  localparam logic [13:0] RECIP5 = 14'd13108;
  localparam logic [14:0] RECIP3 = 15'd21846;

  localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SOLID  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_SOLID   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_VBARS   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_HBANDS  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_WBORDER = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BBORDER = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FLICKER = 4'd6;
  localparam logic [MODE_W-1:0] MODE_RGBROWS = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HALF    = 4'd8;

  localparam logic [COLOR_W-1:0] COL_RED   = 16'hf800;
  localparam logic [COLOR_W-1:0] COL_GREEN = 16'h07e0;
  localparam logic [COLOR_W-1:0] COL_BLUE  = 16'h001f;
  localparam logic [COLOR_W-1:0] COL_WHITE = 16'hffff;
  localparam logic [COLOR_W-1:0] COL_BLACK = 16'h0000;

  localparam logic [MODE_W-1:0]   RST_MODE   = MODE_SOLID;
  localparam logic [DIM_W-1:0]    RST_WIDTH  = 12'd480;
  localparam logic [DIM_W-1:0]    RST_HEIGHT = 12'd854;
  localparam logic [STRIDE_W-1:0] RST_STRIDE = 13'd480;
  localparam logic [COLOR_W-1:0]  RST_SOLID  = 16'h0000;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
    logic [COLOR_W-1:0]  solid;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] w_half;
    logic [DIM_W-1:0] h_half;
    logic [DIM_W-1:0] w_q1;
    logic [DIM_W-1:0] w_q2;
    logic [DIM_W-1:0] w_q3;
    logic [DIM_W-1:0] w_q4;
    logic [DIM_W-1:0] h_q1;
    logic [DIM_W-1:0] h_q2;
    logic [DIM_W-1:0] h_q3;
    logic [DIM_W-1:0] h_q4;
    logic [DIM_W-1:0] h_third;
    logic [DIM_W-1:0] h_two_third;
  } thr_t;

endpackage

// ===== src/dtpg_cfg.sv =====
// Register file of the generator and the band thresholds derived from it.
`timescale 1ns / 1ps
module dtpg_cfg
  import dtpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output thr_t              thr
);

  function automatic thr_t derive(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    logic [25:0] wp;
    logic [25:0] hp;
    logic [26:0] h3p;
    logic [27:0] h23p;
    logic [DIM_W-1:0] wq;
    logic [DIM_W-1:0] hq;
    thr_t t;
    wp   = w * RECIP5;
    hp   = h * RECIP5;
    h3p  = h * RECIP3;
    h23p = {h, 1'b0} * RECIP3;
    wq   = {2'b00, wp[25:16]};
    hq   = {2'b00, hp[25:16]};
    t.w_half      = {1'b0, w[DIM_W-1:1]};
    t.h_half      = {1'b0, h[DIM_W-1:1]};
    t.w_q1        = wq;
    t.w_q2        = {wq[DIM_W-2:0], 1'b0};
    t.w_q3        = {wq[DIM_W-2:0], 1'b0} + wq;
    t.w_q4        = {wq[DIM_W-3:0], 2'b00};
    t.h_q1        = hq;
    t.h_q2        = {hq[DIM_W-2:0], 1'b0};
    t.h_q3        = {hq[DIM_W-2:0], 1'b0} + hq;
    t.h_q4        = {hq[DIM_W-3:0], 2'b00};
    t.h_third     = {1'b0, h3p[26:16]};
    t.h_two_third = h23p[27:16];
    return t;
  endfunction

  cfg_t cfg_r;
  thr_t thr_r;
  logic wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= RST_MODE;
      cfg_r.width  <= RST_WIDTH;
      cfg_r.height <= RST_HEIGHT;
      cfg_r.stride <= RST_STRIDE;
      cfg_r.solid  <= RST_SOLID;
      thr_r        <= derive(RST_WIDTH, RST_HEIGHT);
    end else begin
      if (wr_en) begin
        unique case (idx)
          REG_MODE:   cfg_r.mode   <= pwdata[MODE_W-1:0];
          REG_WIDTH:  cfg_r.width  <= pwdata[DIM_W-1:0];
          REG_HEIGHT: cfg_r.height <= pwdata[DIM_W-1:0];
          REG_STRIDE: cfg_r.stride <= pwdata[STRIDE_W-1:0];
          REG_SOLID:  cfg_r.solid  <= pwdata[COLOR_W-1:0];
          default: ;
        endcase
      end
      thr_r <= derive(cfg_r.width, cfg_r.height);
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {{(APB_DW-MODE_W){1'b0}}, cfg_r.mode};
      REG_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, cfg_r.width};
      REG_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, cfg_r.height};
      REG_STRIDE: prdata = {{(APB_DW-STRIDE_W){1'b0}}, cfg_r.stride};
      REG_SOLID:  prdata = {{(APB_DW-COLOR_W){1'b0}}, cfg_r.solid};
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
  assign thr = thr_r;

endmodule

// ===== src/dtpg_core.sv =====
// Pattern color and frame buffer address of one pixel.
`timescale 1ns / 1ps
module dtpg_core
  import dtpg_pkg::*;
(
  input  cfg_t               cfg,
  input  thr_t               thr,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  output logic [COLOR_W-1:0] color,
  output logic [ADDR_W-1:0]  address
);

  logic [COORD_W+STRIDE_W-1:0] prod;
  logic [COORD_W+14:0]         y3p;
  logic                        in_frame;
  logic                        on_edge;
  logic                        left;
  logic                        top;
  logic [COLOR_W-1:0]          vbar;
  logic [COLOR_W-1:0]          hband;

  assign prod    = y * cfg.stride;
  assign address = prod[ADDR_W-1:0] + {{(ADDR_W-COORD_W){1'b0}}, x};

  assign y3p      = y * RECIP3;
  assign in_frame = ({1'b0, x} < {1'b0, cfg.width}) && ({1'b0, y} < {1'b0, cfg.height});
  assign on_edge  = (x == '0) || (y == '0)
                 || ({1'b0, x} + 13'd1 == {1'b0, cfg.width})
                 || ({1'b0, y} + 13'd1 == {1'b0, cfg.height});
  assign left     = x < thr.w_half;
  assign top      = y < thr.h_half;

  always_comb begin
    if (x < thr.w_q1)      vbar = COL_RED;
    else if (x < thr.w_q2) vbar = COL_GREEN;
    else if (x < thr.w_q3) vbar = COL_BLUE;
    else if (x < thr.w_q4) vbar = COL_BLACK;
    else                   vbar = COL_WHITE;
    if (y < thr.h_q1)      hband = COL_RED;
    else if (y < thr.h_q2) hband = COL_GREEN;
    else if (y < thr.h_q3) hband = COL_BLUE;
    else if (y < thr.h_q4) hband = COL_BLACK;
    else                   hband = COL_WHITE;
  end

  always_comb begin
    color = COL_BLACK;
    if (in_frame) begin
      case (cfg.mode)
        MODE_SOLID:   color = cfg.solid;
        MODE_QUAD:    color = top ? (left ? COL_RED : COL_GREEN)
                                  : (left ? COL_BLUE : COL_WHITE);
        MODE_VBARS:   color = vbar;
        MODE_HBANDS:  color = hband;
        MODE_WBORDER: color = on_edge ? COL_WHITE : COL_BLACK;
        MODE_BBORDER: color = on_edge ? COL_BLACK : COL_WHITE;
        MODE_FLICKER: color = y3p[16] ? COL_BLACK : COL_WHITE;
        MODE_RGBROWS: color = (y < thr.h_third) ? COL_RED
                            : (y < thr.h_two_third) ? COL_GREEN : COL_BLUE;
        MODE_HALF:    color = left ? COL_WHITE : COL_BLACK;
        default:      color = COL_BLACK;
      endcase
    end
  end

endmodule

// ===== src/display_test_pattern_generator.sv =====
// Top level of the display test pattern generator: input stage, pattern logic, result stage.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_pixel_x, in_pixel_y
//   out     | output    | out_valid / out_stall | out_pixel_color, out_pixel_address
//   cfg     | input     | psel/penable/pwrite   | paddr, pwdata, prdata
//
// One item per cycle unless the output stalls; results leave through the result register.
// The path is an input register, the color decode and the y * stride multiply, a result register.
// Band thresholds are held in their own register, loaded from the width and height registers.
// Synchronous reset clears valid flags and loads the register defaults.
// A stalled result holds while the input stage still takes one more item.
`timescale 1ns / 1ps
module display_test_pattern_generator
  import dtpg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_pixel_x,
  input  logic [COORD_W-1:0] in_pixel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic [ADDR_W-1:0]  out_pixel_address,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  thr_t thr;

  logic               s1_valid_r;
  logic [COORD_W-1:0] s1_x_r;
  logic [COORD_W-1:0] s1_y_r;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [COLOR_W-1:0] color_nxt;
  logic [ADDR_W-1:0]  addr_nxt;
  logic               out_free;
  logic               s1_move;
  logic               s1_load;

  dtpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .thr     (thr)
  );

  dtpg_core u_core (
    .cfg     (cfg),
    .thr     (thr),
    .x       (s1_x_r),
    .y       (s1_y_r),
    .color   (color_nxt),
    .address (addr_nxt)
  );

  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_move  = s1_valid_r & out_free;
  assign in_stall = s1_valid_r & ~out_free;
  assign s1_load  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_x_r <= in_pixel_x;
      s1_y_r <= in_pixel_y;
    end
    if (s1_move) begin
      out_color_r <= color_nxt;
      out_addr_r  <= addr_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_color   = out_color_r;
  assign out_pixel_address = out_addr_r;

endmodule

// ===== src/dtpg_checker.sv =====
// Port-level checker of the display test pattern generator and its bind.
`timescale 1ns / 1ps
`include "display_test_pattern_generator_macros.svh"
module dtpg_checker
  import dtpg_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [COORD_W-1:0] in_pixel_x,
  input logic [COORD_W-1:0] in_pixel_y,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COLOR_W-1:0] out_pixel_color,
  input logic [ADDR_W-1:0]  out_pixel_address,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [APB_AW-1:0]  paddr,
  input logic [APB_DW-1:0]  pwdata,
  input logic [APB_DW-1:0]  prdata,
  input logic               pready
);

  `DTPG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_pixel_color) && $stable(out_pixel_address), "stalled item changed")
  `DTPG_ASSERT(a_no_stall_when_empty, !out_valid |-> !in_stall, "input stalled with empty output")
  `DTPG_ASSERT(a_accept_reaches_out, in_valid && !in_stall && !out_valid |-> ##2 out_valid, "accepted item did not reach output")
  `DTPG_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind display_test_pattern_generator dtpg_checker u_dtpg_checker (.*);
